>>> design/sawarq_pkg.sv
// sawarq_pkg: types, codes and constants shared by the stop-and-wait arq sender
// used by sawarq_front, sawarq_cmd_queue, sawarq_back and stop_and_wait_arq_sender_top
// depends on nothing
`timescale 1ns / 1ps

package sawarq_pkg;

    // sequence numbers wrap modulo 2**SEQ_W
    localparam int SEQ_W    = 32;
    localparam int TIMER_W  = 16;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST = TIMER_W'(500);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    // request codes on req_type
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_CONNECT = 3'd1;
    localparam logic [2:0] REQ_SEND    = 3'd2;
    localparam logic [2:0] REQ_CLOSE   = 3'd3;
    localparam logic [2:0] REQ_PACKET  = 3'd4;

    typedef logic [SEQ_W-1:0] t_seq;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_ACKED     = 3'd2,
        ST_CLOSED    = 3'd3,
        ST_PROTO_ERR = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CONNECT,
        OP_SEND,
        OP_CLOSE,
        OP_PACKET,
        OP_BAD
    } t_op;

    // one request beat
    typedef struct packed {
        logic [2:0]  req_type;
        logic        rx_ack;
        logic        rx_syn;
        logic        rx_fin;
        logic [31:0] rx_seq;
        logic [31:0] rx_acknowledge;
    } t_req;

    // one result beat
    typedef struct packed {
        logic        tx_valid;
        logic        tx_syn;
        logic        tx_ack;
        logic        tx_fin;
        logic [31:0] tx_seq;
        logic [31:0] tx_acknowledge;
        logic        is_retransmit;
        t_status     status;
    } t_rsp;

    // classified command passed from front to back
    typedef struct packed {
        t_op   op;
        logic  rx_ack;
        logic  rx_fin;
        logic  synack_ok;     // syn and ack set, acknowledge equals one
        t_seq  rx_acknowledge;
        t_seq  peer_seq_inc;  // peer seq plus one, for the final ack
    } t_cmd;

endpackage

>>> design/sawarq_front.sv
// sawarq_front: decodes a request beat into a command and precomputes packet checks
// depends on sawarq_pkg
`timescale 1ns / 1ps

module sawarq_front (
    input  sawarq_pkg::t_req i_req,
    output sawarq_pkg::t_cmd o_cmd
);
    import sawarq_pkg::*;

    t_seq w_rx_seq;
    t_seq w_rx_an;

    assign w_rx_seq = i_req.rx_seq[SEQ_W-1:0];
    assign w_rx_an  = i_req.rx_acknowledge[SEQ_W-1:0];

    // request classification and header checks that do not depend on state
    always_comb begin
        case (i_req.req_type)
            REQ_TICK:    o_cmd.op = OP_TICK;
            REQ_CONNECT: o_cmd.op = OP_CONNECT;
            REQ_SEND:    o_cmd.op = OP_SEND;
            REQ_CLOSE:   o_cmd.op = OP_CLOSE;
            REQ_PACKET:  o_cmd.op = OP_PACKET;
            default:     o_cmd.op = OP_BAD;
        endcase
        o_cmd.rx_ack         = i_req.rx_ack;
        o_cmd.rx_fin         = i_req.rx_fin;
        o_cmd.synack_ok      = i_req.rx_ack && i_req.rx_syn && (w_rx_an == t_seq'(1));
        o_cmd.rx_acknowledge = w_rx_an;
        o_cmd.peer_seq_inc   = w_rx_seq + t_seq'(1);
    end

endmodule

>>> design/sawarq_cmd_queue.sv
// sawarq_cmd_queue: short command queue that decouples front and back
// depends on sawarq_pkg
`timescale 1ns / 1ps

module sawarq_cmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  sawarq_pkg::t_cmd i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic             o_rd_valid,
    output sawarq_pkg::t_cmd o_rd_data
);
    import sawarq_pkg::*;

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_AW:0]   r_count;

    logic w_wr;
    logic w_rd;

    assign o_full     = (r_count == (CQ_AW+1)'(CQ_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_en && !o_full;
    assign w_rd       = i_rd_en && o_rd_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == CQ_AW'(CQ_DEPTH-1)) ? '0 : r_wr_ptr + CQ_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == CQ_AW'(CQ_DEPTH-1)) ? '0 : r_rd_ptr + CQ_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (CQ_AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (CQ_AW+1)'(1);
            end
        end
    end

endmodule

>>> design/sawarq_back.sv
// sawarq_back: link state machine, retransmit timer and result register
// depends on sawarq_pkg
`timescale 1ns / 1ps

module sawarq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  sawarq_pkg::t_cmd   i_cmd,
    output logic               o_cmd_take,
    input  logic               i_cfg_wr,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_pop,
    output logic               o_empty,
    output sawarq_pkg::t_rsp   o_rsp
);
    import sawarq_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYN_SENT,
        PH_CONNECTED,
        PH_WAIT_DATA,
        PH_WAIT_FIN_ACK,
        PH_WAIT_PEER_FIN
    } t_phase;

    t_phase             r_phase,   n_phase;
    t_seq               r_next,    n_next;
    t_seq               r_pending, n_pending;
    logic [TIMER_W-1:0] r_timer,   n_timer;
    logic [TIMER_W-1:0] r_timeout;
    logic               r_out_vld;
    t_rsp               r_out,     n_out;

    logic [TIMER_W-1:0] w_timer_inc;
    t_seq               w_want;

    // a command runs when the result slot is free or being drained
    assign o_cmd_take  = i_cmd_valid && (!r_out_vld || i_pop);
    assign o_empty     = !r_out_vld;
    assign o_rsp       = r_out;
    assign w_timer_inc = r_timer + TIMER_W'(1);
    assign w_want      = r_pending + t_seq'(1);

    // next state and result for the command at the head of the queue
    always_comb begin
        n_phase   = r_phase;
        n_next    = r_next;
        n_pending = r_pending;
        n_timer   = r_timer;
        n_out     = '0;
        n_out.status = ST_NONE;
        case (i_cmd.op)
            OP_TICK: begin
                if (r_phase == PH_WAIT_DATA) begin
                    if (w_timer_inc >= r_timeout) begin
                        n_timer             = '0;
                        n_out.tx_valid      = 1'b1;
                        n_out.tx_seq        = 32'(r_pending);
                        n_out.is_retransmit = 1'b1;
                    end else begin
                        n_timer = w_timer_inc;
                    end
                end
            end
            OP_CONNECT: begin
                if (r_phase == PH_IDLE) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_syn   = 1'b1;
                    n_phase        = PH_SYN_SENT;
                end else begin
                    n_out.status = ST_IGNORED;
                end
            end
            OP_SEND: begin
                if (r_phase == PH_CONNECTED) begin
                    n_pending      = r_next;
                    n_timer        = '0;
                    n_out.tx_valid = 1'b1;
                    n_out.tx_seq   = 32'(r_next);
                    n_phase        = PH_WAIT_DATA;
                end else begin
                    n_out.status = ST_IGNORED;
                end
            end
            OP_CLOSE: begin
                if (r_phase == PH_CONNECTED) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_fin   = 1'b1;
                    n_out.tx_seq   = 32'(r_next);
                    n_phase        = PH_WAIT_FIN_ACK;
                end else begin
                    n_out.status = ST_IGNORED;
                end
            end
            OP_PACKET: begin
                case (r_phase)
                    PH_SYN_SENT: begin
                        if (i_cmd.synack_ok) begin
                            n_out.tx_valid       = 1'b1;
                            n_out.tx_ack         = 1'b1;
                            n_out.tx_seq         = 32'd1;
                            n_out.tx_acknowledge = 32'd1;
                            n_next               = t_seq'(1);
                            n_phase              = PH_CONNECTED;
                            n_out.status         = ST_CONNECTED;
                        end else begin
                            n_phase      = PH_IDLE;
                            n_out.status = ST_PROTO_ERR;
                        end
                    end
                    PH_WAIT_DATA: begin
                        // unmatched packets are dropped quietly
                        if (i_cmd.rx_ack && (i_cmd.rx_acknowledge == w_want)) begin
                            n_next       = w_want;
                            n_timer      = '0;
                            n_phase      = PH_CONNECTED;
                            n_out.status = ST_ACKED;
                        end
                    end
                    PH_WAIT_FIN_ACK: begin
                        if (i_cmd.rx_ack) begin
                            n_phase = PH_WAIT_PEER_FIN;
                        end else begin
                            n_phase      = PH_IDLE;
                            n_out.status = ST_PROTO_ERR;
                        end
                    end
                    PH_WAIT_PEER_FIN: begin
                        if (i_cmd.rx_fin) begin
                            n_out.tx_valid       = 1'b1;
                            n_out.tx_ack         = 1'b1;
                            n_out.tx_acknowledge = 32'(i_cmd.peer_seq_inc);
                            n_out.status         = ST_CLOSED;
                        end else begin
                            n_out.status = ST_PROTO_ERR;
                        end
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_out.status = ST_IGNORED;
                    end
                endcase
            end
            default: begin
                n_out.status = ST_IGNORED;
            end
        endcase
    end

    // state, timeout register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_next    <= '0;
            r_pending <= '0;
            r_timer   <= '0;
            r_timeout <= TIMEOUT_RST;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_timeout <= i_cfg_data;
            end
            if (o_cmd_take) begin
                r_phase   <= n_phase;
                r_next    <= n_next;
                r_pending <= n_pending;
                r_timer   <= n_timer;
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_out <= n_out;
        end
    end

endmodule

>>> design/stop_and_wait_arq_sender_top.sv
// stop_and_wait_arq_sender_top: sender control for a stop-and-wait link with handshake
// depends on sawarq_pkg, sawarq_front, sawarq_cmd_queue, sawarq_back
//
// channel   | ports                          | beat taken when
// ----------+--------------------------------+------------------------
// request   | push, full, i_req              | push && !full
// result    | empty, pop, o_rsp              | pop && !empty
// config    | i_cfg_valid, o_cfg_ready, data | i_cfg_valid && o_cfg_ready
//
// one request beat per cycle while full is low; every request gives exactly one result beat
// a taken request passes through a queue slot, then the result register, and waits in the
// queue while the result register holds a result that has not been popped
// the command queue holds two beats, so requests keep flowing for a while when pop is low
// reset is synchronous; it clears the queue, the link state and restores the timeout of 500
`timescale 1ns / 1ps

module stop_and_wait_arq_sender_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sawarq_pkg::t_req   i_req,
    output logic               empty,
    input  logic               pop,
    output sawarq_pkg::t_rsp   o_rsp,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import sawarq_pkg::*;

    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_q_valid;
    logic w_q_take;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // request decode
    sawarq_front u_front (
        .i_req (i_req),
        .o_cmd (w_front_cmd)
    );

    // front to back queue
    sawarq_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (push),
        .i_wr_data  (w_front_cmd),
        .o_full     (full),
        .i_rd_en    (w_q_take),
        .o_rd_valid (w_q_valid),
        .o_rd_data  (w_q_cmd)
    );

    // link state machine and result register
    sawarq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_take  (w_q_take),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_rsp       (o_rsp)
    );

endmodule

>>> test/arq_link_checker.sv
// arq_link_checker: watches the request, result and config channels of the arq sender,
// keeps its own copy of the link state and compares every result beat field by field
// depends on sawarq_pkg
`timescale 1ns / 1ps

module arq_link_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  sawarq_pkg::t_req   i_req,
    input  logic               i_empty,
    input  logic               i_pop,
    input  sawarq_pkg::t_rsp   i_rsp,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_in_flight,
    output logic               o_idle,
    output logic               o_syn_sent,
    output logic               o_connected,
    output logic               o_wait_data,
    output logic               o_wait_fin_ack,
    output logic               o_wait_peer_fin,
    output sawarq_pkg::t_seq   o_data_ack
);

    import sawarq_pkg::*;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_SYN_SENT,
        LINK_CONNECTED,
        LINK_WAIT_DATA,
        LINK_WAIT_FIN_ACK,
        LINK_WAIT_PEER_FIN
    } t_link;

    // predicted link state and timeout register
    t_link              link        = LINK_IDLE;
    t_seq               next_seq    = '0;
    t_seq               pending_seq = '0;
    logic [TIMER_W-1:0] wait_timer  = '0;
    logic [TIMER_W-1:0] timeout_cfg = TIMEOUT_RST;

    // headers predicted but not yet popped, oldest first
    t_rsp headers_due[$];

    initial o_mismatches = 0;
    initial o_in_flight  = 0;

    // link phase hints for the stimulus side
    assign o_idle          = (link == LINK_IDLE);
    assign o_syn_sent      = (link == LINK_SYN_SENT);
    assign o_connected     = (link == LINK_CONNECTED);
    assign o_wait_data     = (link == LINK_WAIT_DATA);
    assign o_wait_fin_ack  = (link == LINK_WAIT_FIN_ACK);
    assign o_wait_peer_fin = (link == LINK_WAIT_PEER_FIN);
    assign o_data_ack      = pending_seq + 1'b1;

    function automatic t_rsp header(input logic syn, input logic ack, input logic fin,
                                    input t_seq seq, input t_seq ackn, input logic retx);
        t_rsp h;
        h = '0;
        h.tx_valid       = 1'b1;
        h.tx_syn         = syn;
        h.tx_ack         = ack;
        h.tx_fin         = fin;
        h.tx_seq         = seq;
        h.tx_acknowledge = ackn;
        h.is_retransmit  = retx;
        return h;
    endfunction

    // apply one request to the link state and produce the header it causes
    task automatic advance_link(input t_req r, output t_rsp h);
        t_seq    peer_seq;
        t_seq    peer_ackn;
        t_seq    want;
        t_status st;
        peer_seq  = r.rx_seq[SEQ_W-1:0];
        peer_ackn = r.rx_acknowledge[SEQ_W-1:0];
        want      = pending_seq + 1'b1;
        st        = ST_NONE;
        h         = '0;
        case (r.req_type)
            REQ_TICK: begin
                // timer only runs while a data beat is unacknowledged
                if (link == LINK_WAIT_DATA) begin
                    wait_timer = wait_timer + 1'b1;
                    if (wait_timer >= timeout_cfg) begin
                        wait_timer = '0;
                        h = header(1'b0, 1'b0, 1'b0, pending_seq, '0, 1'b1);
                    end
                end
            end
            REQ_CONNECT: begin
                if (link == LINK_IDLE) begin
                    h    = header(1'b1, 1'b0, 1'b0, '0, '0, 1'b0);
                    link = LINK_SYN_SENT;
                end else begin
                    st = ST_IGNORED;
                end
            end
            REQ_SEND: begin
                if (link == LINK_CONNECTED) begin
                    pending_seq = next_seq;
                    wait_timer  = '0;
                    h    = header(1'b0, 1'b0, 1'b0, next_seq, '0, 1'b0);
                    link = LINK_WAIT_DATA;
                end else begin
                    st = ST_IGNORED;
                end
            end
            REQ_CLOSE: begin
                if (link == LINK_CONNECTED) begin
                    h    = header(1'b0, 1'b0, 1'b1, next_seq, '0, 1'b0);
                    link = LINK_WAIT_FIN_ACK;
                end else begin
                    st = ST_IGNORED;
                end
            end
            REQ_PACKET: begin
                case (link)
                    LINK_SYN_SENT: begin
                        if (r.rx_ack && r.rx_syn && peer_ackn == t_seq'(1)) begin
                            h        = header(1'b0, 1'b1, 1'b0, t_seq'(1), t_seq'(1), 1'b0);
                            next_seq = t_seq'(1);
                            link     = LINK_CONNECTED;
                            st       = ST_CONNECTED;
                        end else begin
                            link = LINK_IDLE;
                            st   = ST_PROTO_ERR;
                        end
                    end
                    LINK_WAIT_DATA: begin
                        // anything but the matching ack is dropped
                        if (r.rx_ack && peer_ackn == want) begin
                            next_seq   = want;
                            wait_timer = '0;
                            link       = LINK_CONNECTED;
                            st         = ST_ACKED;
                        end
                    end
                    LINK_WAIT_FIN_ACK: begin
                        if (r.rx_ack) begin
                            link = LINK_WAIT_PEER_FIN;
                        end else begin
                            link = LINK_IDLE;
                            st   = ST_PROTO_ERR;
                        end
                    end
                    LINK_WAIT_PEER_FIN: begin
                        if (r.rx_fin) begin
                            h  = header(1'b0, 1'b1, 1'b0, '0, peer_seq + 1'b1, 1'b0);
                            st = ST_CLOSED;
                        end else begin
                            st = ST_PROTO_ERR;
                        end
                        link = LINK_IDLE;
                    end
                    default: begin
                        st = ST_IGNORED;
                    end
                endcase
            end
            default: begin
                st = ST_IGNORED;
            end
        endcase
        h.status = st;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            o_mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_rsp due;
        if (!i_rst_n) begin
            link        = LINK_IDLE;
            next_seq    = '0;
            pending_seq = '0;
            wait_timer  = '0;
            timeout_cfg = TIMEOUT_RST;
            headers_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (headers_due.size() == 0) begin
                    o_mismatches++;
                    $display("%0t ns: result beat expected none, got %h", $time, i_rsp);
                end else begin
                    due = headers_due.pop_front();
                    compare_field("tx_valid", 32'(due.tx_valid), 32'(i_rsp.tx_valid));
                    compare_field("tx_syn", 32'(due.tx_syn), 32'(i_rsp.tx_syn));
                    compare_field("tx_ack", 32'(due.tx_ack), 32'(i_rsp.tx_ack));
                    compare_field("tx_fin", 32'(due.tx_fin), 32'(i_rsp.tx_fin));
                    compare_field("tx_seq", due.tx_seq, i_rsp.tx_seq);
                    compare_field("tx_acknowledge", due.tx_acknowledge,
                                  i_rsp.tx_acknowledge);
                    compare_field("is_retransmit", 32'(due.is_retransmit),
                                  32'(i_rsp.is_retransmit));
                    compare_field("status", 32'(due.status), 32'(i_rsp.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                timeout_cfg = i_cfg_data;
            end
            if (i_push && !i_full) begin
                advance_link(i_req, due);
                headers_due.push_back(due);
            end
        end
        o_in_flight = headers_due.size();
    end

endmodule

>>> test/tb_top.sv
// tb_top: drives requests, pops and timeout writes into the arq sender with random idling,
// and reports the verdict from the link checker's mismatch count
// depends on sawarq_pkg, stop_and_wait_arq_sender_top, arq_link_checker
`timescale 1ns / 1ps

module tb_top;

    import sawarq_pkg::*;

    // request codes with no meaning, used to hit the ignore path
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_PER_SETTING = 276;
    localparam int DRAIN_CYCLES       = 4;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam logic [15:0] TIMEOUT_PLAN [7] = '{16'd1, 16'd0, 16'hFFFF, 16'd3,
                                                 16'd500, 16'd2, 16'd6};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    t_req        req_beat  = '0;
    logic        empty;
    logic        pop       = 1'b0;
    t_rsp        rsp_beat;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int   mismatches;
    int   in_flight;
    logic link_idle, link_syn_sent, link_connected;
    logic link_wait_data, link_wait_fin_ack, link_wait_peer_fin;
    t_seq data_ack;

    logic tx_gap_on   = 1'b0;
    logic rx_stall_on = 1'b1;
    logic rsp_taken   = 1'b0;
    int   stall_left  = 0;
    int   quiet_cycles = 0;

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    stop_and_wait_arq_sender_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_req       (req_beat),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (rsp_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    arq_link_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_req           (req_beat),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_rsp           (rsp_beat),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_in_flight     (in_flight),
        .o_idle          (link_idle),
        .o_syn_sent      (link_syn_sent),
        .o_connected     (link_connected),
        .o_wait_data     (link_wait_data),
        .o_wait_fin_ack  (link_wait_fin_ack),
        .o_wait_peer_fin (link_wait_peer_fin),
        .o_data_ack      (data_ack)
    );

    // result side: after each popped beat, hold pop low for a random stall while stalls are on
    always @(posedge clk) begin
        rsp_taken <= rst_n && pop && !empty;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (rsp_taken) begin
                stall_left = rx_stall_on ? $urandom_range(15, 0) : 0;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_req mk(input logic [2:0] req, input logic ack, input logic syn,
                                input logic fin, input logic [31:0] seq,
                                input logic [31:0] ackn);
        t_req r;
        r.req_type       = req;
        r.rx_ack         = ack;
        r.rx_syn         = syn;
        r.rx_fin         = fin;
        r.rx_seq         = seq;
        r.rx_acknowledge = ackn;
        return r;
    endfunction

    // mostly the request the link is waiting for, with random content and some noise
    function automatic t_req next_request();
        t_req r;
        int   roll;
        r = mk(REQ_PACKET, 1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom);
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
            r.req_type = 3'($urandom);
            return r;
        end
        roll = $urandom_range(99, 0);
        if (link_idle) begin
            r.req_type = (roll < 85) ? REQ_CONNECT : REQ_TICK;
        end else if (link_syn_sent) begin
            if (roll < 85) begin
                r.rx_ack         = 1'b1;
                r.rx_syn         = 1'b1;
                r.rx_acknowledge = 32'd1;
            end else if (roll < 93) begin
                r.rx_acknowledge = 32'd1;
                r.rx_syn         = 1'b0;
            end
        end else if (link_connected) begin
            if (roll < 65) begin
                r.req_type = REQ_SEND;
            end else if (roll < 80) begin
                r.req_type = REQ_CLOSE;
            end else begin
                r.req_type = REQ_TICK;
            end
        end else if (link_wait_data) begin
            if (roll < 55) begin
                r.req_type = REQ_TICK;
            end else if (roll < 85) begin
                r.rx_ack         = 1'b1;
                r.rx_acknowledge = data_ack;
            end else if (roll < 93) begin
                r.rx_acknowledge = data_ack ^ ($urandom | 32'd1);
            end else begin
                r.rx_ack         = 1'b0;
                r.rx_acknowledge = data_ack;
            end
        end else if (link_wait_fin_ack) begin
            if (roll < 85) begin
                r.rx_ack = 1'b1;
            end else if (roll < 90) begin
                r.req_type = REQ_TICK;
            end else begin
                r.rx_ack = 1'b0;
            end
        end else begin
            if (roll < 85) begin
                r.rx_fin = 1'b1;
                if (roll < 10) begin
                    r.rx_seq = '1;
                end else if (roll < 20) begin
                    r.rx_seq = '0;
                end
            end else begin
                r.rx_fin = 1'b0;
            end
        end
        return r;
    endfunction

    // one request beat; called and returns at a falling edge, push left high
    task automatic send_req(input t_req r);
        int gap;
        gap = tx_gap_on ? $urandom_range(15, 0) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push     <= 1'b1;
        req_beat <= r;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (in_flight != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int k;
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_timeout(16'd2);

        // wrong-phase requests while idle, extremes of the fields
        send_req(mk(REQ_TICK, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_SEND, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b1, '1, '1));
        send_req(mk(REQ_SPARE_HI, 1'b1, 1'b1, 1'b1, '1, '1));
        send_req(mk(REQ_SPARE_LO, 1'b0, 1'b0, 1'b0, '0, '0));
        // handshake with a bad reply, then a good one
        send_req(mk(REQ_CONNECT, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_CONNECT, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b0, '0, '1));
        send_req(mk(REQ_CONNECT, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b1, '1, 32'd1));
        send_req(mk(REQ_PACKET, 1'b1, 1'b0, 1'b0, '0, 32'd2));
        // data beat, retransmit on timeout, unmatched acks dropped, then matched
        send_req(mk(REQ_SEND, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_SEND, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_TICK, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_TICK, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b0, 1'b0, '0, 32'd1));
        send_req(mk(REQ_PACKET, 1'b0, 1'b0, 1'b0, '0, 32'd2));
        send_req(mk(REQ_PACKET, 1'b1, 1'b0, 1'b0, '0, 32'd2));
        // clean close with peer seq wrapping to zero
        send_req(mk(REQ_CLOSE, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b0, 1'b0, 1'b1, '1, '0));
        // close without ack, then close without peer fin
        send_req(mk(REQ_CONNECT, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b0, '0, 32'd1));
        send_req(mk(REQ_CLOSE, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b0, 1'b1, 1'b1, '1, '1));
        send_req(mk(REQ_CONNECT, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b0, '0, 32'd1));
        send_req(mk(REQ_CLOSE, 1'b0, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b0, 1'b0, '0, '0));
        send_req(mk(REQ_PACKET, 1'b1, 1'b1, 1'b0, '1, '1));

        // random sessions under each timeout setting
        for (k = 0; k < 7; k++) begin
            push <= 1'b0;
            wait_drained();
            write_timeout(TIMEOUT_PLAN[k]);
            for (n = 0; n < RANDOM_PER_SETTING; n++) begin
                if (n % 40 == 0) begin
                    tx_gap_on   = ($urandom_range(2, 0) != 0);
                    rx_stall_on = ($urandom_range(2, 0) != 0);
                end
                send_req(next_request());
            end
        end
        push <= 1'b0;
        wait_drained();

        if (mismatches == 0 && in_flight == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
design/sawarq_pkg.sv
design/sawarq_front.sv
design/sawarq_cmd_queue.sv
design/sawarq_back.sv
design/stop_and_wait_arq_sender_top.sv
test/arq_link_checker.sv
test/tb_top.sv
